// File: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
// Expects signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// File: rtl/stm_pkg.sv
// Package for the 2D sparse table range-minimum block.
// Types, command/status codes and addressing helpers; no dependencies.
`timescale 1ns / 1ps
package stm_pkg;
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int ROW_LEVELS  = 5;
  localparam int COL_LEVELS  = 5;
  localparam int STORE_DEPTH = ROW_LEVELS * COL_LEVELS * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [3:0]                   idx_t;
  typedef logic [4:0]                   size_t5_t;
  typedef logic [2:0]                   lvl_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

  function automatic lvl_t floor_log2(input size_t5_t v);
    if (v >= 5'd16)     return 3'd4;
    else if (v >= 5'd8) return 3'd3;
    else if (v >= 5'd4) return 3'd2;
    else if (v >= 5'd2) return 3'd1;
    else                return 3'd0;
  endfunction

  function automatic addr_t slot(input lvl_t kx, input lvl_t ky, input idx_t r,
                                 input idx_t c);
    logic [4:0] li;
    li = 5'({2'b00, kx} * 5'(COL_LEVELS)) + {2'b00, ky};
    return {li, r, c};
  endfunction

  function automatic data_t smin(input data_t a, input data_t b);
    return (a <= b) ? a : b;
  endfunction

  function automatic size_t5_t clamp_size(input size_t5_t v, input size_t5_t lim);
    if (v == 5'd0)  return 5'd1;
    else if (v > lim) return lim;
    else            return v;
  endfunction
endpackage

// File: rtl/stm_cmd_if.sv
// Command channel interface: valid/ready handshake plus command payload.
// Depends on stm_pkg.
`timescale 1ns / 1ps
interface stm_cmd_if;
  import stm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  idx_t       row_a;
  idx_t       col_a;
  idx_t       row_b;
  idx_t       col_b;
  data_t      value;
  modport source (output valid, command, row_a, col_a, row_b, col_b, value,
                  input ready);
  modport sink   (input valid, command, row_a, col_a, row_b, col_b, value,
                  output ready);
endinterface

// File: rtl/stm_res_if.sv
// Result channel interface: valid/ready handshake plus result payload.
// Depends on stm_pkg.
`timescale 1ns / 1ps
interface stm_res_if;
  import stm_pkg::*;
  logic       valid;
  logic       ready;
  data_t      result_value;
  logic [1:0] status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// File: rtl/sparse_table_2d_range_min.sv
// Top level of the 2D sparse table range-minimum block.
// Depends on stm_pkg, stm_cmd_if, stm_res_if and assert_macros.svh.
//
//   channel  | dir | handshake     | payload
//   cmd      | in  | valid/ready   | command, row_a, col_a, row_b, col_b, value
//   res      | out | valid/ready   | result_value, status
//   cfg      | in  | cfg_we only   | cfg_index, cfg_data (rows_used, cols_used)
//
// Steps: load, error and unbuilt query go from the accept straight to the
// hand-off; a query takes the accept, four reads through the single read port of
// the block store, the fold and the hand-off to the output register.
// Build reads, reads again and then writes for each table entry written.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next command is taken.
// Reset is synchronous; the block store is not cleared and needs no pass.
`timescale 1ns / 1ps
module sparse_table_2d_range_min
  import stm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  stm_cmd_if.sink    cmd,
  stm_res_if.source  res
);
`include "assert_macros.svh"

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_WR   = 7'b0001000,
    S_QRD  = 7'b0010000,
    S_QL   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  state_t     state;
  size_t5_t   rows_used, cols_used;
  logic       table_built;
  lvl_t       kx, ky;
  idx_t       r, c;
  idx_t       qra, qca, qnr, qnc;
  logic [1:0] qidx;
  data_t      acc, a_val;
  data_t      fin_value;
  logic [1:0] fin_status;
  logic       res_valid;
  data_t      res_value;
  logic [1:0] res_status;

  // block store: one write and one registered read per cycle
  data_t      mem [STORE_DEPTH];
  data_t      rdata;
  logic       mem_we;
  addr_t      waddr, raddr;
  data_t      wdata;

  size_t5_t   n, m;
  lvl_t       ln, lm;
  size_t5_t   rlen, clen;
  idx_t       rmax, cmax;
  idx_t       half_r, half_c;
  logic       accept, slot_free, load_ok, q_ok, last_elem;
  lvl_t       qkx, qky;
  idx_t       qnr_calc, qnc_calc;

  assign n  = clamp_size(rows_used, 5'(MAX_ROWS));
  assign m  = clamp_size(cols_used, 5'(MAX_COLS));
  assign ln = floor_log2(n);
  assign lm = floor_log2(m);

  // loop bounds of the current level pair
  assign rlen   = 5'd1 << kx;
  assign clen   = 5'd1 << ky;
  assign rmax   = 4'(n - rlen);
  assign cmax   = 4'(m - clen);
  assign half_r = 4'(5'd1 << (kx - 3'd1));
  assign half_c = 4'(5'd1 << (ky - 3'd1));
  assign last_elem = (c == cmax) && (r == rmax) &&
                     (((kx == 3'd0) && (ky == lm) && (ln == 3'd0)) ||
                      ((kx != 3'd0) && (ky == lm) && (kx == ln)));

  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !res_valid || res.ready;
  assign cmd.ready = (state == S_IDLE);

  assign load_ok = ({1'b0, cmd.row_a} < n) && ({1'b0, cmd.col_a} < m);
  assign q_ok    = (cmd.row_a <= cmd.row_b) && ({1'b0, cmd.row_b} < n) &&
                   (cmd.col_a <= cmd.col_b) && ({1'b0, cmd.col_b} < m);
  assign qkx      = floor_log2(5'(cmd.row_b) - 5'(cmd.row_a) + 5'd1);
  assign qky      = floor_log2(5'(cmd.col_b) - 5'(cmd.col_a) + 5'd1);
  assign qnr_calc = 4'(5'(cmd.row_b) + 5'd1 - (5'd1 << qkx));
  assign qnc_calc = 4'(5'(cmd.col_b) + 5'd1 - (5'd1 << qky));

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    waddr  = slot(kx, ky, r, c);
    wdata  = smin(a_val, rdata);
    raddr  = slot(kx, ky, r, c);
    if (state == S_IDLE && accept && cmd.command == CMD_LOAD && load_ok) begin
      mem_we = 1'b1;
      waddr  = slot(3'd0, 3'd0, cmd.row_a, cmd.col_a);
      wdata  = cmd.value;
    end else if (state == S_WR) begin
      mem_we = 1'b1;
    end
    case (state)
      S_RDA: begin
        if (kx == 3'd0) raddr = slot(kx, ky - 3'd1, r, c);
        else            raddr = slot(kx - 3'd1, ky, r, c);
      end
      S_RDB: begin
        if (kx == 3'd0) raddr = slot(kx, ky - 3'd1, r, c + half_c);
        else            raddr = slot(kx - 3'd1, ky, r + half_r, c);
      end
      S_QRD: begin
        raddr = slot(kx, ky, qidx[0] ? qnr : qra, qidx[1] ? qnc : qca);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_used   <= 5'd16;
      cols_used   <= 5'd16;
      table_built <= 1'b0;
      kx          <= '0;
      ky          <= '0;
      r           <= '0;
      c           <= '0;
      qidx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            fin_value  <= '0;
            fin_status <= STATUS_RANGE;
            state      <= S_FIN;
            case (cmd.command)
              CMD_LOAD: begin
                if (load_ok) begin
                  table_built <= 1'b0;
                  fin_status  <= STATUS_OK;
                end
              end
              CMD_BUILD: begin
                fin_status <= STATUS_OK;
                r <= '0;
                c <= '0;
                if (lm != 3'd0) begin
                  kx <= 3'd0; ky <= 3'd1; state <= S_RDA;
                end else if (ln != 3'd0) begin
                  kx <= 3'd1; ky <= 3'd0; state <= S_RDA;
                end else begin
                  table_built <= 1'b1;
                end
              end
              CMD_QUERY: begin
                if (!table_built) begin
                  fin_status <= STATUS_NOT_BUILT;
                end else if (q_ok) begin
                  fin_status <= STATUS_OK;
                  kx   <= qkx;
                  ky   <= qky;
                  qra  <= cmd.row_a;
                  qca  <= cmd.col_a;
                  qnr  <= qnr_calc;
                  qnc  <= qnc_calc;
                  qidx <= '0;
                  state <= S_QRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          a_val <= rdata;
          state <= S_WR;
        end
        S_WR: begin
          // advance column, then row, then level pair
          state <= S_RDA;
          if (last_elem) begin
            table_built <= 1'b1;
            state       <= S_FIN;
          end else if (c != cmax) begin
            c <= c + 4'd1;
          end else begin
            c <= '0;
            if (r != rmax) begin
              r <= r + 4'd1;
            end else begin
              r <= '0;
              if (ky != lm) begin
                ky <= ky + 3'd1;
              end else if (kx == 3'd0) begin
                kx <= 3'd1; ky <= 3'd0;
              end else begin
                kx <= kx + 3'd1; ky <= 3'd0;
              end
            end
          end
        end
        S_QRD: begin
          if (qidx == 2'd1)      acc <= rdata;
          else if (qidx != 2'd0) acc <= smin(acc, rdata);
          qidx <= qidx + 2'd1;
          if (qidx == 2'd3) state <= S_QL;
        end
        S_QL: begin
          fin_value <= smin(acc, rdata);
          state     <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // register writes take priority over any build completion
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) begin
          rows_used   <= cfg_data;
          table_built <= 1'b0;
        end else if (cfg_index == REG_COLS) begin
          cols_used   <= cfg_data;
          table_built <= 1'b0;
        end
      end
    end
  end

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && slot_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && slot_free) begin
      res_value  <= fin_value;
      res_status <= fin_status;
    end
  end

  assign res.valid        = res_valid;
  assign res.result_value = res_value;
  assign res.status       = res_status;

  `ASSERT_NEXT(a_cfg_clears_built, cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS), !table_built)
  `ASSERT_IMPLIES(a_wr_after_rdb, state == S_WR, $past(state) == S_RDB)
  `ASSERT_NEXT(a_ql_to_fin, state == S_QL, state == S_FIN)
endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for sparse_table_2d_range_min: loads, builds and rectangle queries.
// Depends on stm_pkg, stm_cmd_if, stm_res_if and the block itself.
// A local table model predicts each result, and random gaps and stalls fall on both channels.
`timescale 1ns / 1ps
module testbench;
  import stm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;

  typedef struct packed {
    logic [1:0] command;
    idx_t       row_a;
    idx_t       col_a;
    idx_t       row_b;
    idx_t       col_b;
    data_t      value;
  } cmd_item_t;

  typedef struct packed {
    data_t      result_value;
    logic [1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_ROWS;
  logic [4:0] cfg_data  = 5'd0;

  stm_cmd_if cmd_ch();
  stm_res_if res_ch();

  sparse_table_2d_range_min u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd_ch), .res(res_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block: block minima per level pair, built flag and used sizes.
  data_t      blk_min [ROW_LEVELS][COL_LEVELS][MAX_ROWS][MAX_COLS];
  logic       grid_built;
  logic [4:0] rows_reg, cols_reg;

  cmd_item_t pending_cmds[$];
  answer_t   expected_answers[$];
  int        fail_count, answer_count, query_ok_count, build_count;
  logic      hold_off_req = 1'b0;   // receiver holds off a long stretch when raised

  function automatic int used_len(input logic [4:0] r);
    if (r == 5'd0) return 1;
    if (r > 5'd16) return 16;
    return int'(r);
  endfunction

  function automatic int lg2(input int v);
    int k;
    k = 0;
    while (v > 1) begin
      v = v >> 1;
      k++;
    end
    return k;
  endfunction

  function automatic data_t min2(input data_t a, input data_t b);
    return (a < b) ? a : b;
  endfunction

  // Double along columns first, then along rows.
  function automatic void build_minima();
    int n, m, half;
    n = used_len(rows_reg);
    m = used_len(cols_reg);
    for (int ky = 1; ky <= lg2(m); ky++) begin
      half = 1 << (ky - 1);
      for (int r = 0; r < n; r++)
        for (int c = 0; c + 2 * half <= m; c++)
          blk_min[0][ky][r][c] = min2(blk_min[0][ky-1][r][c], blk_min[0][ky-1][r][c+half]);
    end
    for (int kx = 1; kx <= lg2(n); kx++) begin
      half = 1 << (kx - 1);
      for (int ky = 0; ky <= lg2(m); ky++)
        for (int r = 0; r + 2 * half <= n; r++)
          for (int c = 0; c + (1 << ky) <= m; c++)
            blk_min[kx][ky][r][c] = min2(blk_min[kx-1][ky][r][c],
                                         blk_min[kx-1][ky][r+half][c]);
    end
  endfunction

  function automatic answer_t predict_answer(input cmd_item_t it);
    answer_t a;
    int n, m, kx, ky, nr, nc;
    n = used_len(rows_reg);
    m = used_len(cols_reg);
    a.result_value = '0;
    a.status = STATUS_RANGE;
    case (it.command)
      CMD_LOAD: begin
        if (it.row_a < n && it.col_a < m) begin
          blk_min[0][0][it.row_a][it.col_a] = it.value;
          grid_built = 1'b0;
          a.status = STATUS_OK;
        end
      end
      CMD_BUILD: begin
        build_minima();
        grid_built = 1'b1;
        build_count++;
        a.status = STATUS_OK;
      end
      CMD_QUERY: begin
        if (!grid_built) begin
          a.status = STATUS_NOT_BUILT;
        end else if (it.row_a <= it.row_b && it.row_b < n && it.col_a <= it.col_b &&
                     it.col_b < m) begin
          kx = lg2(it.row_b - it.row_a + 1);
          ky = lg2(it.col_b - it.col_a + 1);
          nr = it.row_b + 1 - (1 << kx);
          nc = it.col_b + 1 - (1 << ky);
          a.result_value = min2(min2(blk_min[kx][ky][it.row_a][it.col_a],
                                     blk_min[kx][ky][nr][it.col_a]),
                                min2(blk_min[kx][ky][it.row_a][nc],
                                     blk_min[kx][ky][nr][nc]));
          a.status = STATUS_OK;
          query_ok_count++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Mostly short gaps, a few long ones; none at all while the no-idle stretch runs.
  logic no_idle = 1'b0;
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the pending queue, predict on each transaction.
  // ---------------------------------------------------------------------------
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_answers.push_back(predict_answer(pending_cmds.pop_front()));
        send_gap = pick_gap();
      end
      if (cmd_ch.valid && !cmd_ch.ready) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= pending_cmds[0].command;
        cmd_ch.row_a   <= pending_cmds[0].row_a;
        cmd_ch.col_a   <= pending_cmds[0].col_a;
        cmd_ch.row_b   <= pending_cmds[0].row_b;
        cmd_ch.col_b   <= pending_cmds[0].col_b;
        cmd_ch.value   <= pending_cmds[0].value;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result channel at random, compare each transaction.
  // ---------------------------------------------------------------------------
  int stall_left, hold_left;
  answer_t want;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        answer_count++;
        if (expected_answers.size() == 0) begin
          $error("result with nothing expected: result_value %0d status %0d",
                 res_ch.result_value, res_ch.status);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (res_ch.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d", want.result_value,
                   res_ch.result_value);
            fail_count++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
          end
        end
        stall_left = pick_gap();
      end
      if (hold_off_req && hold_left == 0) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic cmd_item_t mk(input logic [1:0] c, input int ra, input int ca,
                                   input int rb, input int cb, input int v);
    cmd_item_t it;
    it.command = c;
    it.row_a = idx_t'(ra);
    it.col_a = idx_t'(ca);
    it.row_b = idx_t'(rb);
    it.col_b = idx_t'(cb);
    it.value = data_t'(v);
    return it;
  endfunction

  // Random content, fields left unused by a command still toggle.
  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int r, n, m;
    n = used_len(rows_reg);
    m = used_len(cols_reg);
    it = cmd_item_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 2) begin
      it.command = CMD_BUILD;
    end else if (r < 37) begin
      it.command = CMD_LOAD;
      if ($urandom_range(0, 99) < 85) begin
        it.row_a = idx_t'($urandom_range(0, n - 1));
        it.col_a = idx_t'($urandom_range(0, m - 1));
      end
      if ($urandom_range(0, 9) == 0) it.value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
    end else if (r < 95) begin
      it.command = CMD_QUERY;
      if ($urandom_range(0, 99) < 80) begin
        it.row_a = idx_t'($urandom_range(0, n - 1));
        it.row_b = idx_t'($urandom_range(it.row_a, n - 1));
        it.col_a = idx_t'($urandom_range(0, m - 1));
        it.col_b = idx_t'($urandom_range(it.col_a, m - 1));
      end
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_answers.size() != 0 || cmd_ch.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write both size registers while the block is idle.
  task automatic set_sizes(input logic [4:0] rows, input logic [4:0] cols);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_reg = rows;
    cols_reg = cols;
    grid_built = 1'b0;
  endtask

  task automatic random_phase(input int count);
    pending_cmds.push_back(mk(CMD_BUILD, 0, 0, 0, 0, 0));
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [4:0] sz_r, sz_c;
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_LOAD;
    cmd_ch.row_a = '0;
    cmd_ch.col_a = '0;
    cmd_ch.row_b = '0;
    cmd_ch.col_b = '0;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;
    fail_count = 0;
    answer_count = 0;
    query_ok_count = 0;
    build_count = 0;
    grid_built = 1'b0;
    rows_reg = 5'd16;
    cols_reg = 5'd16;
    for (int a = 0; a < ROW_LEVELS; a++)
      for (int b = 0; b < COL_LEVELS; b++)
        for (int r = 0; r < MAX_ROWS; r++)
          for (int c = 0; c < MAX_COLS; c++) blk_min[a][b][r][c] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: query before build, unused code, then fill the whole grid so that
    // no later build reads an element that was never loaded.
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 15, 15, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 15, 15, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_UNUSED, 15, 15, 15, 15, -1));
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        pending_cmds.push_back(mk(CMD_LOAD, r, c, $urandom, $urandom,
                                  (r == 7 && c == 9) ? -32768 :
                                  (r == 0 && c == 0) ? 32767 : int'($urandom)));
    pending_cmds.push_back(mk(CMD_BUILD, 15, 15, 15, 15, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 15, 15, 0));      // whole grid
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0));        // single cell
    pending_cmds.push_back(mk(CMD_QUERY, 15, 15, 15, 15, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 3, 2, 9, 12, 0));       // non-power-of-two sides
    pending_cmds.push_back(mk(CMD_QUERY, 9, 2, 3, 12, 0));       // reversed rows
    pending_cmds.push_back(mk(CMD_QUERY, 2, 12, 9, 3, 0));       // reversed columns
    pending_cmds.push_back(mk(CMD_LOAD, 4, 4, 0, 0, 100));       // load clears built
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 1, 1, 0));

    // Out-of-grid loads and corners on a small grid.
    set_sizes(5'd4, 5'd3);
    pending_cmds.push_back(mk(CMD_LOAD, 4, 0, 0, 0, 5));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 3, 0, 0, 5));
    pending_cmds.push_back(mk(CMD_BUILD, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 4, 2, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 3, 3, 0));
    pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 3, 2, 0));

    // Extremes of the registers: zero counts as one, above the maximum as the maximum.
    set_sizes(5'd0, 5'd0);
    random_phase(60);
    set_sizes(5'd31, 5'd31);
    no_idle = 1'b1;            // one stretch with no idling on either side
    random_phase(150);
    wait_drained();
    no_idle = 1'b0;

    // Receiver holds off while the sender keeps offering: the block fills and stalls.
    set_sizes(5'd16, 5'd16);
    random_phase(150);
    @(posedge clk);
    hold_off_req <= 1'b1;
    @(posedge clk);
    hold_off_req <= 1'b0;

    set_sizes(5'd16, 5'd1);
    random_phase(80);
    set_sizes(5'd1, 5'd16);
    random_phase(80);
    set_sizes(5'd5, 5'd9);
    random_phase(100);
    repeat (5) begin
      sz_r = 5'($urandom_range(1, 16));
      sz_c = 5'($urandom_range(1, 16));
      set_sizes(sz_r, sz_c);
      random_phase(70);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d results, %0d answered queries and %0d builds over 13 grid sizes",
             answer_count, query_ok_count, build_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", expected_answers.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
